// File: rtl/core/ecu_pkg.sv
// ----------------------------------------------------------------------------
// ecu_pkg
// types, codes and constants shared by the epidemic cell update core
// ----------------------------------------------------------------------------
package ecu_pkg;

   localparam int unsigned STATE_W     = 3;
   localparam int unsigned NEIGHBOURS  = 8;
   localparam int unsigned NBR_W       = NEIGHBOURS * STATE_W;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned CLOCK_W     = 8;
   localparam int unsigned DRAW_W      = 10;
   localparam int unsigned DAY_W       = 10;
   localparam int unsigned LIMIT_W     = 11;
   localparam int unsigned COUNT_W     = 19;
   localparam int unsigned NCOUNT_W    = 4;
   localparam int unsigned SUM_W       = LEVEL_W + NCOUNT_W;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [DAY_W-1:0]   DETECT_DAY  = DAY_W'(10);
   localparam logic [DAY_W-1:0]   RECOVER_DAY = DAY_W'(14);
   localparam logic [CLOCK_W-1:0] QUAR_DAYS   = CLOCK_W'(40);
   localparam logic [CLOCK_W-1:0] CLOCK_MAX   = '1;
   localparam logic [COUNT_W-1:0] TALLY_MAX   = '1;
   localparam logic [LEVEL_W-1:0] STEP_RESET  = LEVEL_W'(6554);

   typedef enum logic [STATE_W-1:0] {
      ST_SUSCEPTIBLE = 3'd0,
      ST_INFECTED    = 3'd1,
      ST_RECOVERED   = 3'd2,
      ST_QUARANTINED = 3'd3,
      ST_EDGE        = 3'd4
   } cell_state_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INFECT_STEP   = 3'd0,
      CSR_DETECT_LIMIT  = 3'd1,
      CSR_RECOVER_LIMIT = 3'd2,
      CSR_DETECT_ENABLE = 3'd3,
      CSR_QUAR_END_DAY  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] infect_step;
      logic [LIMIT_W-1:0] detect_limit;
      logic [LIMIT_W-1:0] recover_limit;
      logic               detection_enable;
      logic [DAY_W-1:0]   quarantine_end_day;
   } cfg_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [LEVEL_W-1:0] level;
      logic [CLOCK_W-1:0] clock;
   } cell_result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] susceptible;
      logic [COUNT_W-1:0] infected;
      logic [COUNT_W-1:0] recovered;
      logic [COUNT_W-1:0] quarantined;
   } counts_type;

endpackage

// File: rtl/core/ecu_cell_rule.sv
// ----------------------------------------------------------------------------
// ecu_cell_rule
// next-generation state, accumulator and clock of one cell
// ----------------------------------------------------------------------------
module ecu_cell_rule
   import ecu_pkg::*;
(
   input  cfg_type             cfg,
   input  logic [STATE_W-1:0]  cell_state,
   input  logic [NBR_W-1:0]    neighbour_states,
   input  logic [LEVEL_W-1:0]  infection_level,
   input  logic [CLOCK_W-1:0]  cell_clock,
   input  logic [DRAW_W-1:0]   random_draw,
   input  logic [DAY_W-1:0]    day,
   output cell_result_type     result
);

   logic [NCOUNT_W-1:0] infected_nbrs;
   logic [SUM_W-1:0]    level_sum;
   logic [CLOCK_W-1:0]  clock_inc;
   logic                detect_hit;
   logic                recover_hit;

   always_comb begin
      infected_nbrs = '0;
      for (int k = 0; k < NEIGHBOURS; k++) begin
         if (neighbour_states[k*STATE_W +: STATE_W] == ST_INFECTED) begin
            infected_nbrs = infected_nbrs + NCOUNT_W'(1);
         end
      end
   end

   assign level_sum   = SUM_W'(infection_level)
                        + SUM_W'(infected_nbrs) * SUM_W'(cfg.infect_step);
   assign clock_inc   = (cell_clock == CLOCK_MAX) ? cell_clock : cell_clock + CLOCK_W'(1);
   assign detect_hit  = cfg.detection_enable && (day > DETECT_DAY)
                        && ({1'b0, random_draw} < cfg.detect_limit);
   assign recover_hit = (day > RECOVER_DAY) && ({1'b0, random_draw} < cfg.recover_limit);

   always_comb begin
      result.state = ST_SUSCEPTIBLE;
      result.level = infection_level;
      result.clock = cell_clock;
      case (cell_state_type'(cell_state))
         ST_SUSCEPTIBLE: begin
            if (level_sum[SUM_W-1:LEVEL_W] != '0) begin
               result.state = ST_INFECTED;
               result.level = '0;
            end else begin
               result.level = level_sum[LEVEL_W-1:0];
            end
         end
         ST_INFECTED: begin
            if (detect_hit) begin
               result.state = ST_QUARANTINED;
            end else if (recover_hit) begin
               result.state = ST_RECOVERED;
               result.clock = '0;
            end else begin
               result.state = ST_INFECTED;
               result.clock = clock_inc;
            end
         end
         ST_RECOVERED: begin
            result.state = ST_RECOVERED;
         end
         ST_QUARANTINED: begin
            if (cell_clock > QUAR_DAYS) begin
               result.state = ST_RECOVERED;
               result.clock = '0;
            end else begin
               result.state = ST_QUARANTINED;
               result.clock = clock_inc;
            end
         end
         ST_EDGE: begin
            result.state = (day < cfg.quarantine_end_day) ? ST_EDGE : ST_SUSCEPTIBLE;
         end
         default: begin
            result.state = ST_SUSCEPTIBLE;
         end
      endcase
   end

endmodule

// File: rtl/core/ecu_tally.sv
// ----------------------------------------------------------------------------
// ecu_tally
// saturating population tallies of one generation, cleared after the last cell
// ----------------------------------------------------------------------------
module ecu_tally
   import ecu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [STATE_W-1:0] next_state,
   input  logic               last_cell,
   output counts_type         counts
);

   counts_type tally_ff;
   counts_type tally_in;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] t,
                                                  input logic hit);
      logic [COUNT_W-1:0] r;
      r = (hit && (t != TALLY_MAX)) ? t + COUNT_W'(1) : t;
      return r;
   endfunction

   // counts including the cell now leaving the input register
   always_comb begin
      counts.susceptible = sat_inc(tally_ff.susceptible, next_state == ST_SUSCEPTIBLE);
      counts.infected    = sat_inc(tally_ff.infected,    next_state == ST_INFECTED);
      counts.recovered   = sat_inc(tally_ff.recovered,   next_state == ST_RECOVERED);
      counts.quarantined = sat_inc(tally_ff.quarantined, next_state == ST_QUARANTINED);
   end

   always_comb begin
      tally_in = tally_ff;
      if (advance) begin
         tally_in = last_cell ? '0 : counts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else begin
         tally_ff <= tally_in;
      end
   end

endmodule

// File: rtl/core/ecu_csr.sv
// ----------------------------------------------------------------------------
// ecu_csr
// configuration register file, written through the csr channel
// ----------------------------------------------------------------------------
module ecu_csr
   import ecu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   write_en,
   input  logic [CSR_INDEX_W-1:0] index,
   input  logic [CSR_DATA_W-1:0]  data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index_type'(index))
            CSR_INFECT_STEP:   cfg_in.infect_step        = data[LEVEL_W-1:0];
            CSR_DETECT_LIMIT:  cfg_in.detect_limit       = data[LIMIT_W-1:0];
            CSR_RECOVER_LIMIT: cfg_in.recover_limit      = data[LIMIT_W-1:0];
            CSR_DETECT_ENABLE: cfg_in.detection_enable   = data[0];
            CSR_QUAR_END_DAY:  cfg_in.quarantine_end_day = data[DAY_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.infect_step        <= STEP_RESET;
         cfg_ff.detect_limit       <= '0;
         cfg_ff.recover_limit      <= '0;
         cfg_ff.detection_enable   <= 1'b0;
         cfg_ff.quarantine_end_day <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/epidemic_cell_update_core.sv
// ----------------------------------------------------------------------------
// epidemic_cell_update_core
// path: an accepted request moves through the input register, then the result register
// throughput: one cell per cycle unless stalled, rule logic sits between the registers
// the tallies update as a cell moves into the result register
// reset: synchronous; clears valids, tallies and loads the register defaults
// ----------------------------------------------------------------------------
module epidemic_cell_update_core
   import ecu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STATE_W-1:0]     req_cell_state,
   input  logic [NBR_W-1:0]       req_neighbour_states,
   input  logic [LEVEL_W-1:0]     req_infection_level,
   input  logic [CLOCK_W-1:0]     req_cell_clock,
   input  logic [DRAW_W-1:0]      req_random_draw,
   input  logic [DAY_W-1:0]       req_day,
   input  logic                   req_last_cell,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATE_W-1:0]     rsp_next_state,
   output logic [LEVEL_W-1:0]     rsp_next_level,
   output logic [CLOCK_W-1:0]     rsp_next_clock,
   output logic [COUNT_W-1:0]     rsp_count_susceptible,
   output logic [COUNT_W-1:0]     rsp_count_infected,
   output logic [COUNT_W-1:0]     rsp_count_recovered,
   output logic [COUNT_W-1:0]     rsp_count_quarantined,
   output logic                   rsp_counts_valid
);

   cfg_type         cfg;
   cell_result_type cell_result;
   counts_type      counts;
   logic            out_load;

   logic               s1_valid_ff, s1_valid_in;
   logic [STATE_W-1:0] s1_state_ff;
   logic [NBR_W-1:0]   s1_nbr_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic [CLOCK_W-1:0] s1_clock_ff;
   logic [DRAW_W-1:0]  s1_draw_ff;
   logic [DAY_W-1:0]   s1_day_ff;
   logic               s1_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   cell_result_type    rsp_result_ff;
   counts_type         rsp_counts_ff, rsp_counts_in;
   logic               rsp_last_ff;

   assign csr_ready = 1'b1;

   ecu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_valid),
      .index    (csr_index),
      .data     (csr_data),
      .cfg      (cfg)
   );

   // request pipeline handshake
   assign out_load     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || out_load;
   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_state_ff <= req_cell_state;
         s1_nbr_ff   <= req_neighbour_states;
         s1_level_ff <= req_infection_level;
         s1_clock_ff <= req_cell_clock;
         s1_draw_ff  <= req_random_draw;
         s1_day_ff   <= req_day;
         s1_last_ff  <= req_last_cell;
      end
   end

   ecu_cell_rule u_rule (
      .cfg              (cfg),
      .cell_state       (s1_state_ff),
      .neighbour_states (s1_nbr_ff),
      .infection_level  (s1_level_ff),
      .cell_clock       (s1_clock_ff),
      .random_draw      (s1_draw_ff),
      .day              (s1_day_ff),
      .result           (cell_result)
   );

   ecu_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .advance    (out_load),
      .next_state (cell_result.state),
      .last_cell  (s1_last_ff),
      .counts     (counts)
   );

   assign rsp_counts_in = s1_last_ff ? counts : '0;

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_result_ff <= cell_result;
         rsp_counts_ff <= rsp_counts_in;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_state        = rsp_result_ff.state;
   assign rsp_next_level        = rsp_result_ff.level;
   assign rsp_next_clock        = rsp_result_ff.clock;
   assign rsp_count_susceptible = rsp_counts_ff.susceptible;
   assign rsp_count_infected    = rsp_counts_ff.infected;
   assign rsp_count_recovered   = rsp_counts_ff.recovered;
   assign rsp_count_quarantined = rsp_counts_ff.quarantined;
   assign rsp_counts_valid      = rsp_last_ff;

endmodule

// File: bench/tb_epidemic_cell_update_core.sv
// ----------------------------------------------------------------------------
// tb_epidemic_cell_update_core
// self-checking regression for the epidemic cell update core: queued cells
// sent in bursts, responses checked against a behavioural model of the cell
// rules and population tallies, register settings changed between drained phases
// ----------------------------------------------------------------------------
module tb_epidemic_cell_update_core
   import ecu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [STATE_W-1:0] state;
      logic [NBR_W-1:0]   nbrs;
      logic [LEVEL_W-1:0] level;
      logic [CLOCK_W-1:0] clk;
      logic [DRAW_W-1:0]  draw;
      logic [DAY_W-1:0]   day;
      logic               last;
   } cell_req_type;

   typedef struct {
      cell_result_type outcome;
      counts_type      counts;
      logic            counts_valid;
   } cell_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [STATE_W-1:0]     req_cell_state = '0;
   logic [NBR_W-1:0]       req_neighbour_states = '0;
   logic [LEVEL_W-1:0]     req_infection_level = '0;
   logic [CLOCK_W-1:0]     req_cell_clock = '0;
   logic [DRAW_W-1:0]      req_random_draw = '0;
   logic [DAY_W-1:0]       req_day = '0;
   logic                   req_last_cell = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATE_W-1:0]     rsp_next_state;
   logic [LEVEL_W-1:0]     rsp_next_level;
   logic [CLOCK_W-1:0]     rsp_next_clock;
   logic [COUNT_W-1:0]     rsp_count_susceptible;
   logic [COUNT_W-1:0]     rsp_count_infected;
   logic [COUNT_W-1:0]     rsp_count_recovered;
   logic [COUNT_W-1:0]     rsp_count_quarantined;
   logic                   rsp_counts_valid;

   cell_req_type cells_to_send[$];
   cell_rsp_type expected_cells[$];
   cell_req_type on_wire;
   cell_rsp_type due;

   cfg_type    shadow_cfg = '{infect_step: STEP_RESET, detect_limit: '0, recover_limit: '0,
                              detection_enable: 1'b0, quarantine_end_day: '0};
   counts_type census = '0;

   int burst_left = 0;
   int idle_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;
   int rx_hold_left = 0;
   int results_seen = 0;
   int mismatches = 0;

   epidemic_cell_update_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cell_state        (req_cell_state),
      .req_neighbour_states  (req_neighbour_states),
      .req_infection_level   (req_infection_level),
      .req_cell_clock        (req_cell_clock),
      .req_random_draw       (req_random_draw),
      .req_day               (req_day),
      .req_last_cell         (req_last_cell),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_next_state        (rsp_next_state),
      .rsp_next_level        (rsp_next_level),
      .rsp_next_clock        (rsp_next_clock),
      .rsp_count_susceptible (rsp_count_susceptible),
      .rsp_count_infected    (rsp_count_infected),
      .rsp_count_recovered   (rsp_count_recovered),
      .rsp_count_quarantined (rsp_count_quarantined),
      .rsp_counts_valid      (rsp_counts_valid)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [COUNT_W-1:0] tally_bump(logic [COUNT_W-1:0] t);
      return (t == TALLY_MAX) ? TALLY_MAX : t + 1'b1;
   endfunction

   // next generation of one cell, plus the running population census
   function automatic cell_rsp_type evolve_cell(cell_req_type c);
      cell_rsp_type       r;
      logic [SUM_W-1:0]   sum;
      logic [CLOCK_W-1:0] clk_up;
      int                 k;
      r.outcome.state = ST_SUSCEPTIBLE;
      r.outcome.level = c.level;
      r.outcome.clock = c.clk;
      clk_up = (c.clk == CLOCK_MAX) ? CLOCK_MAX : c.clk + 1'b1;
      case (c.state)
         ST_SUSCEPTIBLE: begin
            sum = SUM_W'(c.level);
            for (k = 0; k < NEIGHBOURS; k++) begin
               if (c.nbrs[k*STATE_W +: STATE_W] == ST_INFECTED)
                  sum = sum + SUM_W'(shadow_cfg.infect_step);
            end
            if (sum[SUM_W-1:LEVEL_W] != '0) begin
               r.outcome.state = ST_INFECTED;
               r.outcome.level = '0;
            end else begin
               r.outcome.level = sum[LEVEL_W-1:0];
            end
         end
         ST_INFECTED: begin
            if (shadow_cfg.detection_enable && c.day > DETECT_DAY &&
                LIMIT_W'(c.draw) < shadow_cfg.detect_limit) begin
               r.outcome.state = ST_QUARANTINED;
            end else if (c.day > RECOVER_DAY && LIMIT_W'(c.draw) < shadow_cfg.recover_limit) begin
               r.outcome.state = ST_RECOVERED;
               r.outcome.clock = '0;
            end else begin
               r.outcome.state = ST_INFECTED;
               r.outcome.clock = clk_up;
            end
         end
         ST_RECOVERED: r.outcome.state = ST_RECOVERED;
         ST_QUARANTINED: begin
            if (c.clk > QUAR_DAYS) begin
               r.outcome.state = ST_RECOVERED;
               r.outcome.clock = '0;
            end else begin
               r.outcome.state = ST_QUARANTINED;
               r.outcome.clock = clk_up;
            end
         end
         ST_EDGE: begin
            r.outcome.state = (c.day < shadow_cfg.quarantine_end_day) ? ST_EDGE : ST_SUSCEPTIBLE;
         end
         default: r.outcome.state = ST_SUSCEPTIBLE;
      endcase
      case (r.outcome.state)
         ST_SUSCEPTIBLE: census.susceptible = tally_bump(census.susceptible);
         ST_INFECTED:    census.infected    = tally_bump(census.infected);
         ST_RECOVERED:   census.recovered   = tally_bump(census.recovered);
         ST_QUARANTINED: census.quarantined = tally_bump(census.quarantined);
         default: ;
      endcase
      if (c.last) begin
         r.counts = census;
         r.counts_valid = 1'b1;
         census = '0;
      end else begin
         r.counts = '0;
         r.counts_valid = 1'b0;
      end
      return r;
   endfunction

   function automatic cell_req_type mk_cell(logic [STATE_W-1:0] st, logic [NBR_W-1:0] nbrs,
                                            logic [LEVEL_W-1:0] lvl, logic [CLOCK_W-1:0] clk,
                                            logic [DRAW_W-1:0] draw, logic [DAY_W-1:0] day,
                                            logic last);
      cell_req_type c;
      c.state = st;
      c.nbrs  = nbrs;
      c.level = lvl;
      c.clk   = clk;
      c.draw  = draw;
      c.day   = day;
      c.last  = last;
      return c;
   endfunction

   function automatic cell_req_type random_cell();
      cell_req_type c;
      int           pick;
      int           lo;
      int           k;
      pick = $urandom_range(0, 99);
      if (pick < 30)      c.state = ST_SUSCEPTIBLE;
      else if (pick < 60) c.state = ST_INFECTED;
      else if (pick < 68) c.state = ST_RECOVERED;
      else if (pick < 83) c.state = ST_QUARANTINED;
      else if (pick < 95) c.state = ST_EDGE;
      else                c.state = STATE_W'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) begin
         c.nbrs = NBR_W'($urandom);
      end else begin
         for (k = 0; k < NEIGHBOURS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      c.nbrs[k*STATE_W +: STATE_W] = ST_INFECTED;
            else if (pick < 55) c.nbrs[k*STATE_W +: STATE_W] = ST_SUSCEPTIBLE;
            else if (pick < 70) c.nbrs[k*STATE_W +: STATE_W] = ST_RECOVERED;
            else if (pick < 80) c.nbrs[k*STATE_W +: STATE_W] = ST_QUARANTINED;
            else if (pick < 90) c.nbrs[k*STATE_W +: STATE_W] = ST_EDGE;
            else                c.nbrs[k*STATE_W +: STATE_W] = STATE_W'($urandom_range(5, 7));
         end
      end
      case ($urandom_range(0, 2))
         0: c.level = LEVEL_W'($urandom);
         1: begin
            lo = 65535 - int'($urandom_range(0, 8 * shadow_cfg.infect_step));
            c.level = LEVEL_W'((lo < 0) ? 0 : lo);
         end
         default: c.level = LEVEL_W'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 2)       c.clk = CLOCK_W'($urandom_range(38, 43));
      else if (pick == 2) c.clk = CLOCK_W'($urandom_range(250, 255));
      else                c.clk = CLOCK_W'($urandom);
      c.draw = DRAW_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         c.day = DAY_W'($urandom_range(8, 17));
      end else if (pick < 5) begin
         lo = int'(shadow_cfg.quarantine_end_day) + int'($urandom_range(0, 4)) - 2;
         c.day = DAY_W'((lo < 0) ? 0 : ((lo > 1023) ? 1023 : lo));
      end else begin
         c.day = DAY_W'($urandom);
      end
      c.last = ($urandom_range(0, 31) == 0);
      return c;
   endfunction

   function automatic cfg_type draw_settings();
      cfg_type s;
      case ($urandom_range(0, 3))
         0: s.infect_step = LEVEL_W'($urandom_range(1, 65535));
         1: s.infect_step = LEVEL_W'(65535 / $urandom_range(1, 8));
         2: s.infect_step = LEVEL_W'($urandom_range(1, 200));
         default: s.infect_step = LEVEL_W'(65535 - $urandom_range(0, 100));
      endcase
      s.detect_limit       = LIMIT_W'($urandom_range(0, 1024));
      s.recover_limit      = LIMIT_W'($urandom_range(0, 1024));
      s.detection_enable   = 1'($urandom_range(0, 1));
      s.quarantine_end_day = DAY_W'($urandom_range(0, 1023));
      return s;
   endfunction

   task automatic stage_cell(cell_req_type c);
      cells_to_send.insert(cells_to_send.size(), c);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INFECT_STEP:   shadow_cfg.infect_step        = val;
         CSR_DETECT_LIMIT:  shadow_cfg.detect_limit       = val[LIMIT_W-1:0];
         CSR_RECOVER_LIMIT: shadow_cfg.recover_limit      = val[LIMIT_W-1:0];
         CSR_DETECT_ENABLE: shadow_cfg.detection_enable   = val[0];
         CSR_QUAR_END_DAY:  shadow_cfg.quarantine_end_day = val[DAY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_settings(cfg_type s);
      write_reg(CSR_INFECT_STEP,   CSR_DATA_W'(s.infect_step));
      write_reg(CSR_DETECT_LIMIT,  CSR_DATA_W'(s.detect_limit));
      write_reg(CSR_RECOVER_LIMIT, CSR_DATA_W'(s.recover_limit));
      write_reg(CSR_DETECT_ENABLE, CSR_DATA_W'(s.detection_enable));
      write_reg(CSR_QUAR_END_DAY,  CSR_DATA_W'(s.quarantine_end_day));
   endtask

   task automatic queue_random(int count);
      repeat (count) stage_cell(random_cell());
   endtask

   // hold off until every request has been answered and the pipeline is empty
   task automatic settle();
      while (cells_to_send.size() != 0 || req_valid || expected_cells.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     field, results_seen, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            expected_cells.insert(expected_cells.size(), evolve_cell(on_wire));
         if (!req_valid || req_ready) begin
            if (idle_left != 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (cells_to_send.size() != 0) begin
               on_wire = cells_to_send.pop_front();
               req_cell_state       <= on_wire.state;
               req_neighbour_states <= on_wire.nbrs;
               req_infection_level  <= on_wire.level;
               req_cell_clock       <= on_wire.clk;
               req_random_draw      <= on_wire.draw;
               req_day              <= on_wire.day;
               req_last_cell        <= on_wire.last;
               req_valid            <= 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
                  idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               compare_field("unexpected response", 32'h0, 32'h1);
            end else begin
               due = expected_cells.pop_front();
               compare_field("next_state",        32'(due.outcome.state),
                             32'(rsp_next_state));
               compare_field("next_level",        32'(due.outcome.level),
                             32'(rsp_next_level));
               compare_field("next_clock",        32'(due.outcome.clock),
                             32'(rsp_next_clock));
               compare_field("count_susceptible", 32'(due.counts.susceptible),
                             32'(rsp_count_susceptible));
               compare_field("count_infected",    32'(due.counts.infected),
                             32'(rsp_count_infected));
               compare_field("count_recovered",   32'(due.counts.recovered),
                             32'(rsp_count_recovered));
               compare_field("count_quarantined", 32'(due.counts.quarantined),
                             32'(rsp_count_quarantined));
               compare_field("counts_valid",      32'(due.counts_valid),
                             32'(rsp_counts_valid));
            end
            results_seen++;
            if (results_seen == 300 || results_seen == 1200)
               rx_hold_left = 200;
         end
         if (rx_hold_left != 0) begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 3);
               rx_mode_left = $urandom_range(5, 80);
            end else begin
               rx_mode_left--;
            end
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   initial begin
      cfg_type plan;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      queue_random(40);
      settle();

      plan = '{infect_step: 16'd16384, detect_limit: 11'd512, recover_limit: 11'd768,
               detection_enable: 1'b1, quarantine_end_day: 10'd500};
      program_settings(plan);
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o00000000, 16'd0, 8'd7, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o00001111, 16'd0, 8'd0, 10'd100, 10'd3, 1'b0));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o00000111, 16'd16383, 8'd9, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o11111111, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 1'b0));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o56756756, 16'd1234, 8'd0, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o77777777, 16'd0, 8'd0, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd555, 8'd3, 10'd0, 10'd11, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'd3, 10'd0, 10'd10, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'd3, 10'd511, 10'd11, 1'b1));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'd3, 10'd512, 10'd15, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'hFF, 10'h3FF, 10'h3FF, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'd20, 10'd600, 10'd14, 1'b0));
      stage_cell(mk_cell(ST_INFECTED, 24'o0, 16'd0, 8'd20, 10'd767, 10'd15, 1'b0));
      stage_cell(mk_cell(ST_RECOVERED, 24'o77777777, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 1'b0));
      stage_cell(mk_cell(ST_QUARANTINED, 24'o0, 16'd0, 8'd40, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_QUARANTINED, 24'o0, 16'd0, 8'd41, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_QUARANTINED, 24'o0, 16'd0, 8'hFF, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_QUARANTINED, 24'o0, 16'd0, 8'd0, 10'd0, 10'd0, 1'b0));
      stage_cell(mk_cell(ST_EDGE, 24'o0, 16'd77, 8'd9, 10'd0, 10'd499, 1'b0));
      stage_cell(mk_cell(ST_EDGE, 24'o0, 16'd77, 8'd9, 10'd0, 10'd500, 1'b0));
      stage_cell(mk_cell(3'd5, 24'o11111111, 16'd4321, 8'd12, 10'd0, 10'd20, 1'b0));
      stage_cell(mk_cell(3'd6, 24'o0, 16'hFFFF, 8'hFF, 10'd5, 10'd20, 1'b0));
      stage_cell(mk_cell(3'd7, 24'o0, 16'd9, 8'd1, 10'd5, 10'd20, 1'b1));
      stage_cell(mk_cell(ST_SUSCEPTIBLE, 24'o00000001, 16'd0, 8'd0, 10'd0, 10'd0, 1'b1));
      stage_cell(mk_cell(ST_EDGE, 24'o0, 16'd0, 8'd0, 10'd0, 10'h3FF, 1'b1));
      settle();

      plan = '{infect_step: 16'hFFFF, detect_limit: 11'd1024, recover_limit: 11'd1024,
               detection_enable: 1'b1, quarantine_end_day: 10'd1023};
      program_settings(plan);
      queue_random(400);
      settle();

      plan = '{infect_step: 16'd1, detect_limit: 11'd0, recover_limit: 11'd0,
               detection_enable: 1'b0, quarantine_end_day: 10'd0};
      program_settings(plan);
      queue_random(400);
      settle();

      repeat (3) begin
         program_settings(draw_settings());
         queue_random(330);
         settle();
      end
      repeat (8) @(posedge clock);

      if (mismatches == 0 && expected_cells.size() == 0)
         $display("epidemic_cell_update_core regression: pass");
      else
         $display("epidemic_cell_update_core regression: fail");
      $finish;
   end

   initial begin
      #24_000_000;
      $display("epidemic_cell_update_core regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ecu_pkg.sv
rtl/core/ecu_cell_rule.sv
rtl/core/ecu_tally.sv
rtl/core/ecu_csr.sv
rtl/core/epidemic_cell_update_core.sv
bench/tb_epidemic_cell_update_core.sv
